/* hw/rtl/swc_pkg.sv */
// ----------------------------------------------------------------------------
// swc_pkg: shared definitions of the square-wave channel
// Event codes, register indexes, widths and the duty pattern table.
// ----------------------------------------------------------------------------
package swc_pkg;

    // Field widths
    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 11;
    localparam int LEVEL_W  = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;
    localparam int PERIOD_W = 16;
    localparam int LENGTH_W = 8;

    // Event codes
    localparam logic [FUNC_W-1:0] FUNC_TIMER       = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUARTER     = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_HALF        = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_PERIOD = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_LENGTH = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_ENV_RESTART = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SWEEP_RELOAD = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MODE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONSTANT_VOLUME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE_FLAGS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_CONTROL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_ENABLED  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ONES_NEGATE     = 3'd7;

    // Audible period range
    localparam logic [PERIOD_W-1:0] PERIOD_MIN = 16'h0008;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'h07FF;

    // Envelope full-scale level
    localparam logic [3:0] ENV_FULL = 4'd15;

    // Duty patterns, one row per mode, bit i is step i
    localparam logic [7:0] DUTY_TABLE [4] = '{
        8'b0000_0010,
        8'b0000_0110,
        8'b0001_1110,
        8'b1111_1001
    };

    function automatic logic duty_bit(input logic [1:0] mode, input logic [2:0] step);
        logic [7:0] row;
        row = DUTY_TABLE[mode];
        return row[step];
    endfunction

endpackage

/* hw/rtl/square_wave_channel_core.sv */
// ----------------------------------------------------------------------------
// square_wave_channel_core: one square-wave sound channel
// Applies timer, envelope, sweep, length and load events to the channel
// state and returns the resulting 4-bit output level for every item.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------
//  event in | in        | i_in_valid / o_in_ready    | i_func, i_value
//  level    | out       | o_out_valid / i_out_ready  | o_level
//  config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An accepted item waits in the input register; when it is processed, the
// state is updated and its level is loaded into the result register.
// One item is taken per cycle unless the output stalls; a new item can
// enter while a result waits. A stalled output holds the input register,
// and input ready drops only when both are full.
// Reset (synchronous, active low) clears all but data regs; config is always accepted.
// ----------------------------------------------------------------------------
module square_wave_channel_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [swc_pkg::FUNC_W-1:0]        i_func,
    input  logic [swc_pkg::VALUE_W-1:0]       i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [swc_pkg::LEVEL_W-1:0]       o_level,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [swc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [swc_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int PW = swc_pkg::PERIOD_W;
    localparam int LW = swc_pkg::LENGTH_W;

    // Configuration registers
    logic       r_channel_enabled;
    logic [1:0] r_duty_mode;
    logic [3:0] r_constant_volume;
    logic [3:0] r_envelope_period;
    logic [1:0] r_envelope_flags;
    logic [7:0] r_sweep_control;
    logic       r_length_enabled;
    logic       r_ones_negate;

    // Input and output stages
    logic                          r_in_valid;
    logic [swc_pkg::FUNC_W-1:0]    r_in_func;
    logic [swc_pkg::VALUE_W-1:0]   r_in_value;
    logic                          r_out_valid;
    logic [swc_pkg::LEVEL_W-1:0]   r_out_level;

    // Channel state
    logic [PW-1:0] r_period, n_period;
    logic [PW-1:0] r_timer, n_timer;
    logic [2:0]    r_duty_step, n_duty_step;
    logic [3:0]    r_env_div, n_env_div;
    logic [3:0]    r_env_level, n_env_level;
    logic          r_env_restart, n_env_restart;
    logic [2:0]    r_sweep_div, n_sweep_div;
    logic          r_sweep_restart, n_sweep_restart;
    logic [LW-1:0] r_length, n_length;
    logic [swc_pkg::LEVEL_W-1:0] n_level;

    logic          proc;
    logic          sweep_on;
    logic [2:0]    sweep_div_load;
    logic [PW-1:0] sweep_delta;
    logic [PW-1:0] sweep_target;

    assign proc        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || proc;
    assign o_out_valid = r_out_valid;
    assign o_level     = r_out_level;
    assign o_cfg_ready = 1'b1;

    // Sweep target period
    assign sweep_on       = r_sweep_control[7];
    assign sweep_div_load = r_sweep_control[6:4];
    assign sweep_delta    = r_period >> r_sweep_control[2:0];
    assign sweep_target   = r_sweep_control[3]
                          ? r_period - sweep_delta - {{(PW-1){1'b0}}, r_ones_negate}
                          : r_period + sweep_delta;

    // Apply one event to the channel state
    always_comb begin
        n_period        = r_period;
        n_timer         = r_timer;
        n_duty_step     = r_duty_step;
        n_env_div       = r_env_div;
        n_env_level     = r_env_level;
        n_env_restart   = r_env_restart;
        n_sweep_div     = r_sweep_div;
        n_sweep_restart = r_sweep_restart;
        n_length        = r_length;

        // Envelope step, shared by quarter and half frames
        if (r_in_func == swc_pkg::FUNC_QUARTER || r_in_func == swc_pkg::FUNC_HALF) begin
            if (r_env_restart) begin
                n_env_level   = swc_pkg::ENV_FULL;
                n_env_div     = r_envelope_period;
                n_env_restart = 1'b0;
            end else if (r_env_div != 4'd0) begin
                n_env_div = r_env_div - 4'd1;
            end else begin
                if (r_env_level != 4'd0) begin
                    n_env_level = r_env_level - 4'd1;
                end else if (r_envelope_flags[1]) begin
                    n_env_level = swc_pkg::ENV_FULL;
                end
                n_env_div = r_envelope_period;
            end
        end

        unique case (r_in_func)
            swc_pkg::FUNC_TIMER: begin
                if (r_timer == '0) begin
                    n_timer     = r_period;
                    n_duty_step = r_duty_step + 3'd1;
                end else begin
                    n_timer = r_timer - {{(PW-1){1'b0}}, 1'b1};
                end
            end
            swc_pkg::FUNC_HALF: begin
                // Sweep unit
                if (r_sweep_restart) begin
                    if (sweep_on && r_sweep_div == 3'd0) begin
                        n_period = sweep_target;
                    end
                    n_sweep_div     = sweep_div_load;
                    n_sweep_restart = 1'b0;
                end else if (r_sweep_div != 3'd0) begin
                    n_sweep_div = r_sweep_div - 3'd1;
                end else begin
                    if (sweep_on) begin
                        n_period = sweep_target;
                    end
                    n_sweep_div = sweep_div_load;
                end
                // Length counter
                if (r_length_enabled && r_length != '0) begin
                    n_length = r_length - {{(LW-1){1'b0}}, 1'b1};
                end
            end
            swc_pkg::FUNC_LOAD_PERIOD: begin
                n_period = {{(PW-swc_pkg::VALUE_W){1'b0}}, r_in_value};
            end
            swc_pkg::FUNC_LOAD_LENGTH: begin
                n_length = r_in_value[LW-1:0];
            end
            swc_pkg::FUNC_ENV_RESTART: begin
                n_env_restart = 1'b1;
            end
            swc_pkg::FUNC_SWEEP_RELOAD: begin
                n_sweep_restart = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Output level from the updated state
    always_comb begin
        if (!r_channel_enabled || n_length == '0
            || !swc_pkg::duty_bit(r_duty_mode, n_duty_step)
            || n_period < swc_pkg::PERIOD_MIN || n_period > swc_pkg::PERIOD_MAX) begin
            n_level = '0;
        end else if (r_envelope_flags[0]) begin
            n_level = n_env_level;
        end else begin
            n_level = r_constant_volume;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_enabled <= 1'b0;
            r_duty_mode       <= '0;
            r_constant_volume <= '0;
            r_envelope_period <= '0;
            r_envelope_flags  <= '0;
            r_sweep_control   <= '0;
            r_length_enabled  <= 1'b0;
            r_ones_negate     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                swc_pkg::REG_CHANNEL_ENABLED: r_channel_enabled <= i_cfg_data[0];
                swc_pkg::REG_DUTY_MODE:       r_duty_mode       <= i_cfg_data[1:0];
                swc_pkg::REG_CONSTANT_VOLUME: r_constant_volume <= i_cfg_data[3:0];
                swc_pkg::REG_ENVELOPE_PERIOD: r_envelope_period <= i_cfg_data[3:0];
                swc_pkg::REG_ENVELOPE_FLAGS:  r_envelope_flags  <= i_cfg_data[1:0];
                swc_pkg::REG_SWEEP_CONTROL:   r_sweep_control   <= i_cfg_data;
                swc_pkg::REG_LENGTH_ENABLED:  r_length_enabled  <= i_cfg_data[0];
                swc_pkg::REG_ONES_NEGATE:     r_ones_negate     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input register: capture an item, drop it once processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_func  <= i_func;
            r_in_value <= i_value;
        end
    end

    // Channel state: advance on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period        <= '0;
            r_timer         <= '0;
            r_duty_step     <= '0;
            r_env_div       <= '0;
            r_env_level     <= '0;
            r_env_restart   <= 1'b0;
            r_sweep_div     <= '0;
            r_sweep_restart <= 1'b0;
            r_length        <= '0;
        end else if (proc) begin
            r_period        <= n_period;
            r_timer         <= n_timer;
            r_duty_step     <= n_duty_step;
            r_env_div       <= n_env_div;
            r_env_level     <= n_env_level;
            r_env_restart   <= n_env_restart;
            r_sweep_div     <= n_sweep_div;
            r_sweep_restart <= n_sweep_restart;
            r_length        <= n_length;
        end
    end

    // Result register: load on processing, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_level <= n_level;
        end
    end

endmodule

/* hw/rtl/swc_checker.sv */
// ----------------------------------------------------------------------------
// swc_checker: port-level checks of the square-wave channel
// Watches handshakes and the level output of the top level over time.
// ----------------------------------------------------------------------------
module swc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [swc_pkg::LEVEL_W-1:0]   o_level,
    input logic                          o_cfg_ready
);

    // Reset empties the result register
    assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A waiting result holds its level
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(o_out_valid) && !$past(i_out_ready))
            |-> (o_out_valid && $stable(o_level)))
        else $error("stalled result changed or dropped");

    // With no pending result the block can always take an item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // An offered item with a free output stage enters at once
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_out_valid) |-> (o_in_ready && o_cfg_ready))
        else $error("item refused while output free");

endmodule

bind square_wave_channel_core swc_checker u_swc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_level     (o_level),
    .o_cfg_ready (o_cfg_ready)
);
